// ----- rtl/playfair_pair_substitution_unit_assert.svh -----
// assertion macros shared by the playfair substitution rtl
`ifndef PLAYFAIR_PAIR_SUBSTITUTION_UNIT_ASSERT_SVH
`define PLAYFAIR_PAIR_SUBSTITUTION_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PFS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define PFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pfs_pkg.sv -----
// shared constants, types and helper functions of the playfair substitution unit
`default_nettype none

package pfs_pkg;

   localparam int LETTER_W     = 5;
   localparam int SIDE_W       = 3;
   localparam int SQUARE_CELLS = 25;
   localparam int LETTER_COUNT = 26;
   localparam int KEY_SLOTS    = 32;
   localparam int KEY_MAX      = 25;
   localparam int LOW_LETTERS  = 9;
   localparam int MID_LETTERS  = 9;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 45;
   localparam int KEY_LOW_W   = 45;
   localparam int KEY_MID_W   = 45;
   localparam int KEY_HIGH_W  = 35;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_MID    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LENGTH = 3'd3;

   localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X     = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_LAST  = 5'd25;
   localparam logic [LETTER_W-1:0] LETTER_LIMIT = 5'd26;
   localparam logic [LETTER_W-1:0] CELL_LIMIT   = 5'd25;
   localparam logic [SIDE_W-1:0]   SIDE_LAST    = 3'd4;

   typedef enum logic [1:0] {
      BUILD_KEY,
      BUILD_FILL,
      BUILD_DONE
   } build_state_type;

   typedef enum logic [1:0] {
      KIND_LOOKUP,
      KIND_ZERO,
      KIND_X
   } result_kind_type;

   // one write into the square and position tables
   typedef struct packed {
      logic                sq_we;
      logic                pos_we;
      logic [LETTER_W-1:0] slot;
      logic [LETTER_W-1:0] letter;
   } sq_write_type;

   typedef struct packed {
      logic busy;
      logic fault;
   } build_status_type;

   // row of a cell index 0..24: multiply by 13/64 in place of divide by 5
   function automatic logic [SIDE_W-1:0] cell_row(input logic [LETTER_W-1:0] pos);
      logic [8:0] prod;
      prod = 9'(pos) * 9'd13;
      return prod[8:6];
   endfunction

   function automatic logic [SIDE_W-1:0] cell_col(input logic [LETTER_W-1:0] pos,
                                                  input logic [SIDE_W-1:0]   row);
      logic [LETTER_W-1:0] base;
      base = LETTER_W'({row, 2'b00}) + LETTER_W'(row);
      return SIDE_W'(pos - base);
   endfunction

   function automatic logic [LETTER_W-1:0] cell_index(input logic [SIDE_W-1:0] row,
                                                      input logic [SIDE_W-1:0] col);
      return LETTER_W'({row, 2'b00}) + LETTER_W'(row) + LETTER_W'(col);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pfs_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module pfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pfs_builder.sv -----
// key registers and the sequencer that builds the square after each key write
`default_nettype none
`include "playfair_pair_substitution_unit_assert.svh"

module pfs_builder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pfs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output pfs_pkg::sq_write_type                 wr,
   output pfs_pkg::build_status_type             status
);

   import pfs_pkg::*;

   logic [KEY_LOW_W-1:0]  key_low_ff;
   logic [KEY_MID_W-1:0]  key_mid_ff;
   logic [KEY_HIGH_W-1:0] key_high_ff;
   logic [LETTER_W-1:0]   key_len_ff;

   build_state_type       state_ff, state_in;
   logic [LETTER_W-1:0]   idx_ff, idx_in;
   logic [LETTER_W-1:0]   n_ff, n_in;
   logic [KEY_SLOTS-1:0]  used_ff, used_in;
   logic                  fault_ff, fault_in;

   logic [LETTER_W-1:0]   key_arr [KEY_SLOTS];
   logic [LETTER_W-1:0]   key_used_len;
   logic [LETTER_W-1:0]   key_letter;
   logic                  restart;

   assign restart = csr_we && (csr_index <= REG_KEY_LENGTH);

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_mid_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KEY_LOW:    key_low_ff  <= csr_wdata[KEY_LOW_W-1:0];
            REG_KEY_MID:    key_mid_ff  <= csr_wdata[KEY_MID_W-1:0];
            REG_KEY_HIGH:   key_high_ff <= csr_wdata[KEY_HIGH_W-1:0];
            REG_KEY_LENGTH: key_len_ff  <= csr_wdata[LETTER_W-1:0];
            default: ;
         endcase
      end
   end

   // key letters as one indexable row, unused slots zero
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (i < LOW_LETTERS) begin
            key_arr[i] = key_low_ff[i*LETTER_W +: LETTER_W];
         end else if (i < LOW_LETTERS + MID_LETTERS) begin
            key_arr[i] = key_mid_ff[(i-LOW_LETTERS)*LETTER_W +: LETTER_W];
         end else if (i < KEY_MAX) begin
            key_arr[i] = key_high_ff[(i-LOW_LETTERS-MID_LETTERS)*LETTER_W +: LETTER_W];
         end else begin
            key_arr[i] = '0;
         end
      end
   end

   assign key_used_len = (key_len_ff > CELL_LIMIT) ? CELL_LIMIT : key_len_ff;
   assign key_letter   = key_arr[idx_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in = BUILD_KEY;
      end else begin
         unique case (state_ff)
            BUILD_KEY:  if (idx_ff >= key_used_len) state_in = BUILD_FILL;
            BUILD_FILL: if (idx_ff == LETTER_LAST) state_in = BUILD_DONE;
            BUILD_DONE: state_in = BUILD_DONE;
            default:    state_in = BUILD_KEY;
         endcase
      end
   end

   // table writes and counters
   always_comb begin
      wr       = '0;
      idx_in   = idx_ff;
      n_in     = n_ff;
      used_in  = used_ff;
      fault_in = fault_ff;
      if (restart) begin
         idx_in   = '0;
         n_in     = '0;
         used_in  = '0;
         fault_in = 1'b0;
      end else begin
         unique case (state_ff)
            BUILD_KEY: begin
               if (idx_ff < key_used_len) begin
                  wr.sq_we            = 1'b1;
                  wr.pos_we           = key_letter < LETTER_LIMIT;
                  wr.slot             = n_ff;
                  wr.letter           = key_letter;
                  fault_in            = fault_ff || (key_letter >= LETTER_LIMIT) ||
                                        (key_letter == LETTER_J) || used_ff[key_letter];
                  used_in[key_letter] = 1'b1;
                  n_in                = n_ff + 1'b1;
                  idx_in              = idx_ff + 1'b1;
               end else begin
                  idx_in = '0;
               end
            end
            BUILD_FILL: begin
               if ((idx_ff != LETTER_J) && !used_ff[idx_ff] && (n_ff < CELL_LIMIT)) begin
                  wr.sq_we  = 1'b1;
                  wr.pos_we = 1'b1;
                  wr.slot   = n_ff;
                  wr.letter = idx_ff;
                  n_in      = n_ff + 1'b1;
               end
               if (idx_ff != LETTER_LAST) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            BUILD_DONE: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BUILD_KEY;
         idx_ff   <= '0;
         n_ff     <= '0;
         used_ff  <= '0;
         fault_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         used_ff  <= used_in;
         fault_ff <= fault_in;
      end
   end

   assign status.busy  = state_ff != BUILD_DONE;
   assign status.fault = fault_ff;

   `PFS_ASSERT_SAME(a_full_square, clock, reset,
      (state_ff == BUILD_DONE) && !fault_ff, n_ff == CELL_LIMIT,
      "clean key left the square short of 25 cells")
   `PFS_ASSERT_SAME(a_no_write_done, clock, reset,
      state_ff == BUILD_DONE, !wr.sq_we && !wr.pos_we,
      "table write after the square was complete")
   `PFS_ASSERT_SAME(a_key_cell, clock, reset,
      (state_ff == BUILD_KEY) && wr.sq_we, n_ff == idx_ff,
      "key letter written away from its own cell")

endmodule

`default_nettype wire

// ----- rtl/pfs_lookup.sv -----
// three stage lookup pipeline: letter positions, row and column, square cell
`default_nettype none
`include "playfair_pair_substitution_unit_assert.svh"

module pfs_lookup (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pfs_pkg::sq_write_type          wr,
   input  wire pfs_pkg::build_status_type      status,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [pfs_pkg::LETTER_W-1:0]   req_first,
   input  wire logic [pfs_pkg::LETTER_W-1:0]   req_second,
   input  wire logic                           req_decipher,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [pfs_pkg::LETTER_W-1:0]   rsp_result,
   output logic                                rsp_fault
);

   import pfs_pkg::*;

   logic en1, en2, en3, accept;

   // stage 1: position reads in flight
   logic                v1_ff, bad1_ff, eq1_ff, dec1_ff;
   logic [LETTER_W-1:0] addr_a, addr_b, pa_rd, pb_rd;

   // stage 2: rows and columns
   logic                v2_ff, dec2_ff;
   result_kind_type     kind2_ff, kind2_in;
   logic [SIDE_W-1:0]   ra2_ff, ca2_ff, rb2_ff, cb2_ff;
   logic [SIDE_W-1:0]   ra_in, ca_in, rb_in, cb_in;

   // stage 3: square cell read, output word
   logic                v3_ff, fault3_ff;
   result_kind_type     kind3_ff;
   logic [LETTER_W-1:0] cell_in, sq_rd;
   logic [SIDE_W-1:0]   row_up, row_dn, col_lt, col_rt;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = !status.busy && en1;
   assign accept    = req_valid && req_ready;

   // j shares the cell of i; codes past z read a harmless entry
   assign addr_a = (req_first == LETTER_J) ? LETTER_I :
                   (req_first >= LETTER_LIMIT) ? '0 : req_first;
   assign addr_b = (req_second == LETTER_J) ? LETTER_I :
                   (req_second >= LETTER_LIMIT) ? '0 : req_second;

   pfs_ram #(.WIDTH(LETTER_W), .DEPTH(LETTER_COUNT)) u_pos_a (
      .clock (clock),
      .we    (wr.pos_we),
      .waddr (wr.letter),
      .wdata (wr.slot),
      .re    (en1),
      .raddr (addr_a),
      .rdata (pa_rd)
   );

   pfs_ram #(.WIDTH(LETTER_W), .DEPTH(LETTER_COUNT)) u_pos_b (
      .clock (clock),
      .we    (wr.pos_we),
      .waddr (wr.letter),
      .wdata (wr.slot),
      .re    (en1),
      .raddr (addr_b),
      .rdata (pb_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         bad1_ff <= (req_first >= LETTER_LIMIT) || (req_second >= LETTER_LIMIT);
         eq1_ff  <= req_first == req_second;
         dec1_ff <= req_decipher;
      end
   end

   always_comb begin
      ra_in = cell_row(pa_rd);
      ca_in = cell_col(pa_rd, ra_in);
      rb_in = cell_row(pb_rd);
      cb_in = cell_col(pb_rd, rb_in);
      priority if (status.fault || bad1_ff) begin
         kind2_in = KIND_ZERO;
      end else if (eq1_ff) begin
         kind2_in = KIND_X;
      end else begin
         kind2_in = KIND_LOOKUP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         kind2_ff <= kind2_in;
         dec2_ff  <= dec1_ff;
         ra2_ff   <= ra_in;
         ca2_ff   <= ca_in;
         rb2_ff   <= rb_in;
         cb2_ff   <= cb_in;
      end
   end

   // wrapping neighbours of the first letter
   assign row_up = (ra2_ff == '0) ? SIDE_LAST : ra2_ff - 1'b1;
   assign row_dn = (ra2_ff == SIDE_LAST) ? '0 : ra2_ff + 1'b1;
   assign col_lt = (ca2_ff == '0) ? SIDE_LAST : ca2_ff - 1'b1;
   assign col_rt = (ca2_ff == SIDE_LAST) ? '0 : ca2_ff + 1'b1;

   always_comb begin
      priority if (ca2_ff == cb2_ff) begin
         cell_in = cell_index(dec2_ff ? row_up : row_dn, ca2_ff);
      end else if (ra2_ff == rb2_ff) begin
         cell_in = cell_index(ra2_ff, dec2_ff ? col_lt : col_rt);
      end else begin
         cell_in = cell_index(ra2_ff, cb2_ff);
      end
   end

   pfs_ram #(.WIDTH(LETTER_W), .DEPTH(SQUARE_CELLS)) u_square (
      .clock (clock),
      .we    (wr.sq_we),
      .waddr (wr.slot),
      .wdata (wr.letter),
      .re    (en3),
      .raddr (cell_in),
      .rdata (sq_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         kind3_ff  <= kind2_ff;
         fault3_ff <= status.fault;
      end
   end

   always_comb begin
      unique case (kind3_ff)
         KIND_ZERO:   rsp_result = '0;
         KIND_X:      rsp_result = LETTER_X;
         KIND_LOOKUP: rsp_result = sq_rd;
         default:     rsp_result = '0;
      endcase
   end

   assign rsp_valid = v3_ff;
   assign rsp_fault = fault3_ff;

   `PFS_ASSERT_NEXT(a_no_entry_busy, clock, reset,
      status.busy && en1, !v1_ff,
      "word entered the pipeline while the square was being built")
   `PFS_ASSERT_NEXT(a_out_hold, clock, reset,
      v3_ff && !rsp_ready, v3_ff && $stable(sq_rd) && $stable(kind3_ff),
      "stalled output word changed")
   `PFS_ASSERT_NEXT(a_bad_zero, clock, reset,
      v1_ff && bad1_ff && en2, kind2_ff == KIND_ZERO,
      "out of range letter not forced to zero")

endmodule

`default_nettype wire

// ----- rtl/playfair_pair_substitution_unit.sv -----
// an accepted word passes the position reads, the row and column registers and the square cell
// read, in that order, before its result word is valid
// throughput: one letter pair per cycle, stalls on the result side back up stage by stage
// the square is rebuilt after reset and after every key register write: the key letters first,
// then the rest of the alphabet, req_tready low throughout
// reset is synchronous and active high; it clears the key to empty (square a to z less j)
`default_nettype none

module playfair_pair_substitution_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request side
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,   // first_letter, second_letter, zero
   input  wire logic                            req_tuser,   // decipher
   // result side
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [7:0]                      rsp_tdata,   // result_letter, zero
   output logic                                 rsp_tuser,   // key_fault
   // key register writes
   input  wire logic                            csr_we,
   input  wire logic [pfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import pfs_pkg::*;

   sq_write_type        wr;
   build_status_type    status;
   logic [LETTER_W-1:0] result_letter;

   // builder owns the key registers and fills both lookup tables
   pfs_builder u_builder (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr        (wr),
      .status    (status)
   );

   // pipeline: positions of both letters, then row and column, then the square cell
   pfs_lookup u_lookup (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .status       (status),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_first    (req_tdata[LETTER_W-1:0]),
      .req_second   (req_tdata[2*LETTER_W-1:LETTER_W]),
      .req_decipher (req_tuser),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result_letter),
      .rsp_fault    (rsp_tuser)
   );

   // result letter in the low bits, padded to a byte
   assign rsp_tdata = {{(8-LETTER_W){1'b0}}, result_letter};

endmodule

`default_nettype wire
